FILE: design/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

`endif

FILE: design/hwbm_pkg.sv
package hwbm_pkg;

	localparam int SAMPLE_BITS   = 12;
	localparam int FRACTION_BITS = 8;
	localparam int AVG_W         = SAMPLE_BITS + FRACTION_BITS;
	localparam int WIN_W         = 8;
	localparam int PROD_W        = AVG_W + WIN_W;
	localparam int DIV_W         = PROD_W + 1;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 16;

	localparam logic [7:0]  RST_REFRESH_PERIOD = 8'd200;
	localparam logic [7:0]  RST_SAMPLE_PERIOD  = 8'd100;
	localparam logic [7:0]  RST_AVERAGE_WINDOW = 8'd60;
	localparam logic [7:0]  RST_REPORT_PERIOD  = 8'd20;
	localparam logic [15:0] RST_SETTLE_TIME    = 16'd2000;
	localparam logic        RST_REPORT_ENABLE  = 1'b0;
	localparam logic [7:0]  COUNT_MAX          = 8'hFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_REFRESH_PERIOD = 3'd0,
		REG_SAMPLE_PERIOD  = 3'd1,
		REG_AVERAGE_WINDOW = 3'd2,
		REG_REPORT_PERIOD  = 3'd3,
		REG_SETTLE_TIME    = 3'd4,
		REG_REPORT_ENABLE  = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic                   alive_main;
		logic                   alive_beep;
		logic                   alive_radio;
		logic                   reboot_request;
		logic [SAMPLE_BITS-1:0] battery_sample;
		logic [31:0]            uptime_ticks;
	} tick_t;

	typedef struct packed {
		logic             kick;
		logic             sample_taken;
		logic [AVG_W-1:0] battery_average;
		logic             average_changed;
		logic             report_valid;
	} res_t;

endpackage

FILE: design/hwbm_div.sv
module hwbm_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [hwbm_pkg::DIV_W-1:0]   dividend,
	input  logic [hwbm_pkg::WIN_W-1:0]   divisor,
	output logic                         done,
	output logic [hwbm_pkg::AVG_W-1:0]   quotient
);
	import hwbm_pkg::*;

	localparam int CNT_W = $clog2(DIV_W + 1);

	logic [DIV_W-1:0] work_q;
	logic [WIN_W-1:0] rem_q;
	logic [WIN_W-1:0] dsr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [WIN_W:0]   shifted;
	logic             fits;
	logic [WIN_W:0]   diff;

	// One restoring step per cycle; quotient bits shift in where dividend bits leave.
	assign shifted = {rem_q, work_q[DIV_W-1]};
	assign fits    = shifted >= {1'b0, dsr_q};
	assign diff    = shifted - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= dividend;
			rem_q  <= '0;
			dsr_q  <= divisor;
		end else if (busy_q) begin
			work_q <= {work_q[DIV_W-2:0], fits};
			rem_q  <= fits ? diff[WIN_W-1:0] : shifted[WIN_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = work_q[AVG_W-1:0];

endmodule

FILE: design/heartbeat_watchdog_battery_monitor_unit.sv
// Heartbeat watchdog supervisor with a running battery average.
// Input channel tick/tick_valid/tick_stall carries one supervisor tick per
// transfer; output channel res/res_valid/res_stall returns exactly one result
// per tick, in order. Configuration registers are written through
// cfg_we/cfg_index/cfg_data; the user must write them only while the block
// is idle, as the block itself does not enforce it.
// A tick without a blended sample goes from S_IDLE straight to S_FIN; a tick
// that blends a sample passes S_MUL for the multiply-add, then S_DIV, where
// the restoring divider produces one quotient bit per cycle over 29 bits,
// before S_FIN loads the result. The block takes no new tick until it is back
// in S_IDLE.
// tick_stall is high while a tick is being processed.
// The result sits in an output register; a stall on the result side holds
// it and the block can still take the next tick, but it will not finish
// that tick until the held result has been transferred.
// Reset clears all counters, flags and the average and loads the default
// register values (200, 100, 60, 20, 2000, reports disabled).
module heartbeat_watchdog_battery_monitor_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              tick_valid,
	output logic                              tick_stall,
	input  hwbm_pkg::tick_t                   tick,
	output logic                              res_valid,
	input  logic                              res_stall,
	output hwbm_pkg::res_t                    res,
	input  logic                              cfg_we,
	input  logic [hwbm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [hwbm_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import hwbm_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_FIN} state_t;

	state_t           state_q;
	logic [7:0]       refresh_period_q;
	logic [7:0]       sample_period_q;
	logic [WIN_W-1:0] average_window_q;
	logic [7:0]       report_period_q;
	logic [15:0]      settle_time_q;
	logic             report_enable_q;

	logic [7:0]       refresh_count_q;
	logic             main_seen_q;
	logic             beep_seen_q;
	logic             radio_seen_q;
	logic             reboot_pending_q;
	logic [7:0]       sample_count_q;
	logic [AVG_W-1:0] average_q;
	logic [AVG_W-1:0] previous_q;
	logic [7:0]       report_count_q;

	logic             kick_q;
	logic             taken_q;
	logic             copy_q;
	logic [AVG_W-1:0] scaled_q;
	logic [AVG_W-1:0] blended_q;
	res_t             res_q;
	logic             res_valid_q;

	logic             accept;
	logic             main_now;
	logic             beep_now;
	logic             radio_now;
	logic             reboot_now;
	logic [7:0]       refresh_next;
	logic             decide;
	logic [7:0]       sample_next;
	logic             take;
	logic             copy;
	logic [PROD_W-1:0] product;
	logic [DIV_W-1:0] dividend;
	logic             div_start;
	logic             div_done;
	logic [AVG_W-1:0] quotient;
	logic             out_free;
	logic             load_res;
	logic [AVG_W-1:0] new_avg;
	logic             changed;
	logic [7:0]       report_next;
	logic             report;

	assign accept     = tick_valid && (state_q == S_IDLE);
	assign tick_stall = (state_q != S_IDLE);

	// Pulses on this tick count toward the decision made on this tick.
	assign main_now     = main_seen_q | tick.alive_main;
	assign beep_now     = beep_seen_q | tick.alive_beep;
	assign radio_now    = radio_seen_q | tick.alive_radio;
	assign reboot_now   = reboot_pending_q | tick.reboot_request;
	assign refresh_next = refresh_count_q + 8'd1;
	assign decide       = (refresh_next == refresh_period_q);
	assign sample_next  = sample_count_q + 8'd1;
	assign take         = (sample_next >= sample_period_q);
	// A window of zero or one, or an uptime below the settle time, reduces the blend to a plain copy.
	assign copy = (tick.uptime_ticks < {16'd0, settle_time_q})
		|| (average_window_q <= WIN_W'(1));

	assign product   = {{WIN_W{1'b0}}, average_q}
		* {{AVG_W{1'b0}}, average_window_q - WIN_W'(1)};
	assign dividend  = {1'b0, product} + DIV_W'(scaled_q);
	assign div_start = (state_q == S_MUL);

	hwbm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (average_window_q),
		.done     (div_done),
		.quotient (quotient)
	);

	assign out_free = !res_valid_q || !res_stall;
	assign load_res = (state_q == S_FIN) && out_free;

	always_comb begin
		new_avg     = average_q;
		changed     = 1'b0;
		report_next = report_count_q;
		report      = 1'b0;
		if (taken_q) begin
			new_avg     = copy_q ? scaled_q : blended_q;
			changed     = (new_avg != previous_q);
			report_next = (report_count_q == COUNT_MAX) ? COUNT_MAX
				: report_count_q + 8'd1;
			if (report_enable_q && (report_next >= report_period_q)) begin
				report      = 1'b1;
				report_next = 8'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			refresh_period_q <= RST_REFRESH_PERIOD;
			sample_period_q  <= RST_SAMPLE_PERIOD;
			average_window_q <= RST_AVERAGE_WINDOW;
			report_period_q  <= RST_REPORT_PERIOD;
			settle_time_q    <= RST_SETTLE_TIME;
			report_enable_q  <= RST_REPORT_ENABLE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_REFRESH_PERIOD: refresh_period_q <= cfg_data[7:0];
				REG_SAMPLE_PERIOD:  sample_period_q  <= cfg_data[7:0];
				REG_AVERAGE_WINDOW: average_window_q <= cfg_data[WIN_W-1:0];
				REG_REPORT_PERIOD:  report_period_q  <= cfg_data[7:0];
				REG_SETTLE_TIME:    settle_time_q    <= cfg_data[15:0];
				REG_REPORT_ENABLE:  report_enable_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= S_IDLE;
			refresh_count_q  <= '0;
			main_seen_q      <= 1'b0;
			beep_seen_q      <= 1'b0;
			radio_seen_q     <= 1'b0;
			reboot_pending_q <= 1'b0;
			sample_count_q   <= '0;
			average_q        <= '0;
			previous_q       <= '0;
			report_count_q   <= '0;
			kick_q           <= 1'b0;
			taken_q          <= 1'b0;
			copy_q           <= 1'b0;
			res_valid_q      <= 1'b0;
		end else begin
			if (load_res) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						reboot_pending_q <= reboot_now;
						kick_q  <= decide && main_now && beep_now && radio_now
							&& !reboot_now;
						if (decide) begin
							refresh_count_q <= 8'd0;
							main_seen_q     <= 1'b0;
							beep_seen_q     <= 1'b0;
							radio_seen_q    <= 1'b0;
						end else begin
							refresh_count_q <= refresh_next;
							main_seen_q     <= main_now;
							beep_seen_q     <= beep_now;
							radio_seen_q    <= radio_now;
						end
						sample_count_q <= take ? 8'd0 : sample_next;
						taken_q        <= take;
						copy_q         <= copy;
						state_q        <= (take && !copy) ? S_MUL : S_FIN;
					end
				end
				S_MUL: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						average_q      <= new_avg;
						report_count_q <= report_next;
						if (changed) begin
							previous_q <= new_avg;
						end
						state_q <= S_IDLE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			scaled_q <= AVG_W'(tick.battery_sample) << FRACTION_BITS;
		end
		if ((state_q == S_DIV) && div_done) begin
			blended_q <= quotient;
		end
		if ((state_q == S_FIN) && out_free) begin
			res_q.kick            <= kick_q;
			res_q.sample_taken    <= taken_q;
			res_q.battery_average <= new_avg;
			res_q.average_changed <= changed;
			res_q.report_valid    <= report;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

FILE: design/hwbm_chk.sv
`include "assert_macros.svh"

module hwbm_chk (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            tick_valid,
	input logic                            tick_stall,
	input hwbm_pkg::tick_t                 tick,
	input logic                            res_valid,
	input logic                            res_stall,
	input hwbm_pkg::res_t                  res,
	input logic                            cfg_we,
	input logic [hwbm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input logic [hwbm_pkg::CFG_DATA_W-1:0] cfg_data
);
	import hwbm_pkg::*;

	logic unused_inputs;
	assign unused_inputs = ^{tick, cfg_we, cfg_index, cfg_data};

	// A held result must not change or vanish.
	`ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res))

	// Every tick keeps the block busy for at least the following cycle.
	`ASSERT_NEXT(a_busy_after_tick, tick_valid && !tick_stall, tick_stall)

	// Change and report flags only come with a sample.
	`ASSERT_SAME(a_flags_need_sample, res_valid && !res.sample_taken,
		!res.average_changed && !res.report_valid)

	// Without a sample the average stays where the previous result left it; checked after a held result.
	`ASSERT_SAME(a_avg_held, res_valid && !res.sample_taken && $past(res_valid)
		&& $past(res_stall), res.battery_average == $past(res.battery_average))

endmodule

bind heartbeat_watchdog_battery_monitor_unit hwbm_chk u_hwbm_chk (.*);
